// ----- hdl/bpfa_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and field widths for the bitmap page frame allocator.
// No dependencies; imported by the interfaces, the record scanner and the top level.
package bpfa_pkg;

    // default geometry
    localparam int RECORD_BITS_DEF = 24;
    localparam int NUM_RECORDS_DEF = 1024;

    // request and response field widths
    localparam int PAGE_W = 40;
    localparam int CNT_W  = 15;
    localparam int TAG_W  = 3;
    localparam int KIND_W = 2;
    localparam int NREG_W = 11;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLAIM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TYPE  = 2'd3;

    // register port
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_BIT = 3;
    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_NREC  = 1'b1;

    localparam logic [TAG_W-1:0] TAG_UNTYPED = '0;

endpackage

// ----- hdl/bpfa_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the page frame allocator.
// Depends on bpfa_pkg for the field widths.
interface bpfa_cmd_if import bpfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  count;
    logic [TAG_W-1:0]  type_tag;

    modport source (output valid, kind, page, count, type_tag, input ready);
    modport sink   (input valid, kind, page, count, type_tag, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [PAGE_W-1:0] run_page;
    logic [CNT_W-1:0]  pages_done;
    logic [TAG_W-1:0]  page_type;
    logic [CNT_W-1:0]  free_pages;

    modport source (output valid, ok, run_page, pages_done, page_type, free_pages,
                    input ready);
    modport sink   (input valid, ok, run_page, pages_done, page_type, free_pages,
                    output ready);
endinterface

// ----- hdl/bpfa_scan.sv -----
`timescale 1ns / 1ps
// Downward free-run search over one record bitmap, starting at bit start_bit.
// Depends on bpfa_pkg for the count width.
module bpfa_scan import bpfa_pkg::*; #(
    parameter int RECORD_BITS = RECORD_BITS_DEF
) (
    input  logic [RECORD_BITS-1:0]         bmp,
    input  logic [$clog2(RECORD_BITS)-1:0] start_bit,
    input  logic [CNT_W:0]                 run_in,
    input  logic [CNT_W-1:0]               count,
    output logic                           hit,
    output logic [$clog2(RECORD_BITS)-1:0] hit_pos,
    output logic [CNT_W:0]                 run_out
);

    localparam int BW = $clog2(RECORD_BITS);

    logic [RECORD_BITS-1:0] free_v;
    logic [RECORD_BITS-1:0] all_free;
    logic [RECORD_BITS-1:0] win_ok;
    logic [RECORD_BITS-1:0] hit_v;
    logic [BW-1:0]          low_used;

    // free bits, with bits above the start treated as free
    always_comb
    begin
        for (int j = 0; j < RECORD_BITS; j++)
        begin
            free_v[j] = !bmp[j] || (j > int'(start_bit));
        end
    end

    // per-bit run tests: continuing run from above, or a window inside this record
    always_comb
    begin
        for (int k = 0; k < RECORD_BITS; k++)
        begin
            all_free[k] = 1'b1;
            win_ok[k]   = (int'(count) <= int'(start_bit) - k + 1);
            for (int j = 0; j < RECORD_BITS; j++)
            begin
                if (j >= k && !free_v[j])
                begin
                    all_free[k] = 1'b0;
                end
                if (j >= k && j < k + int'(count) && bmp[j])
                begin
                    win_ok[k] = 1'b0;
                end
            end
            hit_v[k] = (k <= int'(start_bit)) &&
                       ((all_free[k] &&
                         (int'(run_in) + int'(start_bit) - k + 1 >= int'(count))) ||
                        win_ok[k]);
        end
    end

    // highest hit is the first one met going down
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int k = 0; k < RECORD_BITS; k++)
        begin
            if (hit_v[k])
            begin
                hit     = 1'b1;
                hit_pos = BW'(k);
            end
        end
    end

    // run carried into the next record below
    always_comb
    begin
        low_used = '0;
        for (int k = RECORD_BITS - 1; k >= 0; k--)
        begin
            if (bmp[k] && k <= int'(start_bit))
            begin
                low_used = BW'(k);
            end
        end
        if (all_free[0])
        begin
            run_out = run_in + (CNT_W+1)'(start_bit) + (CNT_W+1)'(1);
        end
        else
        begin
            run_out = (CNT_W+1)'(low_used);
        end
    end

endmodule

// ----- hdl/bitmap_page_frame_allocator.sv -----
`timescale 1ns / 1ps
// Bitmap page frame allocator: one region of up to NUM_RECORDS records of RECORD_BITS pages,
// each record a bitmap plus a type tag held in one single-port-read record memory. After reset
// a clearing pass writes every record before the first request is taken. Each request is
// decoded, then reads one record at a time: a type read reads one record, free and claim the
// records touched, allocate the records scanned downward and then the records marked. The
// record memory port reads one record per cycle. Requests are taken while the previous
// response still waits. Depends on bpfa_pkg, bpfa_if and bpfa_scan.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
    parameter int RECORD_BITS = RECORD_BITS_DEF,
    parameter int NUM_RECORDS = NUM_RECORDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bpfa_cmd_if.sink              cmd,
    bpfa_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW    = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
    localparam int BW    = $clog2(RECORD_BITS);
    localparam int NR_W  = $clog2(NUM_RECORDS + 1);
    localparam int TOT_W = $clog2(NUM_RECORDS * RECORD_BITS + 1);
    localparam int ENT_W = RECORD_BITS + TAG_W;
    localparam int RUN_W = CNT_W + 1;
    localparam logic [RECORD_BITS-1:0] FULL = {RECORD_BITS{1'b1}};

    // reciprocal for splitting an offset into record and bit
    localparam int DIV_S  = TOT_W + BW;
    localparam int PROD_W = TOT_W + DIV_S + 1;
    localparam logic [PROD_W-1:0] DIV_M = PROD_W'((64'd1 << DIV_S) / RECORD_BITS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_TOUCH = 3'd5;
    localparam logic [2:0] S_TYPE  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [PAGE_W-1:0] base_reg;
    logic [NR_W-1:0]   nrec_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [TOT_W-1:0]  off_reg, off_next;
    logic [AW-1:0]     rec_reg, rec_next;
    logic [BW-1:0]     bit_reg, bit_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  done_reg, done_next;
    logic              set_reg, set_next;
    logic              first_reg, first_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              ok_reg, ok_next;
    logic [PAGE_W-1:0] run_page_reg, run_page_next;
    logic [TAG_W-1:0]  ptype_reg, ptype_next;
    logic              ovalid_reg, ovalid_next;
    logic              o_ok_reg, o_ok_next;
    logic [PAGE_W-1:0] o_run_page_reg, o_run_page_next;
    logic [CNT_W-1:0]  o_done_reg, o_done_next;
    logic [TAG_W-1:0]  o_ptype_reg, o_ptype_next;
    logic [CNT_W-1:0]  o_free_reg, o_free_next;

    logic [ENT_W-1:0] mem [NUM_RECORDS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata;

    logic [TOT_W-1:0]       total;
    logic [PAGE_W:0]        diff;
    logic [PAGE_W-1:0]      tot40;
    logic [PAGE_W-1:0]      top;
    logic                   in_region;
    logic                   alloc_go;
    logic [RECORD_BITS-1:0] rd_bmp;
    logic [TAG_W-1:0]       rd_tag;
    logic                   elig;
    logic                   scan_hit;
    logic [BW-1:0]          scan_pos;
    logic [RUN_W-1:0]       scan_run;
    logic [BW:0]            tn;
    logic [RECORD_BITS-1:0] tmask;
    logic [RECORD_BITS-1:0] changed;
    logic [RECORD_BITS-1:0] new_bmp;
    logic [CNT_W-1:0]       chg_cnt;
    logic [TAG_W-1:0]       eff_tag;
    logic [AW:0]            rec_inc;
    logic [TOT_W-1:0]       start_off;
    logic [31:0]            free_w;
    logic                   cfg_wr;
    logic [NREG_W-1:0]      nrec_w;
    logic [PROD_W-1:0]      div_prod;
    logic [AW-1:0]          off_rec;
    logic [BW-1:0]          off_bit;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign nrec_w = pwdata[NREG_W-1:0];
    assign prdata = (paddr[REG_IDX_BIT] == REG_NREC) ? APB_DATA_W'(nrec_reg)
                                                     : APB_DATA_W'(base_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            nrec_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[REG_IDX_BIT] == REG_BASE)
            begin
                base_reg <= pwdata[PAGE_W-1:0];
            end
            else if (int'(nrec_w) > NUM_RECORDS)
            begin
                nrec_reg <= NR_W'(NUM_RECORDS);
            end
            else
            begin
                nrec_reg <= NR_W'(nrec_w);
            end
        end
    end

    // record memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // region decode
    assign total  = TOT_W'(int'(nrec_reg) * RECORD_BITS);
    assign tot40  = PAGE_W'(total);
    assign diff   = {1'b0, page_reg} - {1'b0, base_reg};
    assign in_region = !diff[PAGE_W] && (diff[PAGE_W-1:0] < tot40);
    assign alloc_go = (cnt_reg != '0) && (total != '0) && !diff[PAGE_W] &&
                      (diff[PAGE_W-1:0] != '0);
    assign top    = (diff[PAGE_W-1:0] > tot40) ? tot40 : diff[PAGE_W-1:0];

    // offset split into record index and bit position
    assign div_prod = PROD_W'(off_reg) * DIV_M;
    assign off_rec  = AW'(div_prod >> DIV_S);
    assign off_bit  = BW'(off_reg - TOT_W'(int'(off_rec) * RECORD_BITS));

    // record fields
    assign rd_bmp = rd_data_reg[RECORD_BITS-1:0];
    assign rd_tag = rd_data_reg[ENT_W-1 -: TAG_W];
    assign elig   = ((rd_tag == TAG_UNTYPED) || (rd_tag == tag_reg)) && (rd_bmp != FULL);

    bpfa_scan #(
        .RECORD_BITS (RECORD_BITS)
    ) u_scan (
        .bmp       (rd_bmp),
        .start_bit (bit_reg),
        .run_in    (run_reg),
        .count     (cnt_reg),
        .hit       (scan_hit),
        .hit_pos   (scan_pos),
        .run_out   (scan_run)
    );

    // run marking within the current record
    always_comb
    begin
        if (int'(rem_reg) < RECORD_BITS - int'(bit_reg))
        begin
            tn = (BW+1)'(rem_reg);
        end
        else
        begin
            tn = (BW+1)'(RECORD_BITS - int'(bit_reg));
        end
        for (int j = 0; j < RECORD_BITS; j++)
        begin
            tmask[j] = (j >= int'(bit_reg)) && (j < int'(bit_reg) + int'(tn));
        end
        changed = set_reg ? (tmask & ~rd_bmp) : (tmask & rd_bmp);
        new_bmp = set_reg ? (rd_bmp | tmask) : (rd_bmp & ~tmask);
        chg_cnt = CNT_W'($countones(changed));
        eff_tag = (first_reg && kind_reg == KIND_FREE) ? rd_tag : tag_reg;
    end

    assign rec_inc   = {1'b0, rec_reg} + (AW+1)'(1);
    assign start_off = TOT_W'(int'(rec_reg) * RECORD_BITS + int'(scan_pos));
    assign free_w    = (32'(total) > 32'(used_reg)) ? 32'(total) - 32'(used_reg) : 32'd0;

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        page_next       = page_reg;
        cnt_next        = cnt_reg;
        tag_next        = tag_reg;
        off_next        = off_reg;
        rec_next        = rec_reg;
        bit_next        = bit_reg;
        run_next        = run_reg;
        rem_next        = rem_reg;
        done_next       = done_reg;
        set_next        = set_reg;
        first_next      = first_reg;
        used_next       = used_reg;
        clr_next        = clr_reg;
        ok_next         = ok_reg;
        run_page_next   = run_page_reg;
        ptype_next      = ptype_reg;
        ovalid_next     = ovalid_reg && !rsp.ready;
        o_ok_next       = o_ok_reg;
        o_run_page_next = o_run_page_reg;
        o_done_next     = o_done_reg;
        o_ptype_next    = o_ptype_reg;
        o_free_next     = o_free_reg;
        mem_re          = 1'b0;
        mem_raddr       = rec_reg;
        mem_we          = 1'b0;
        mem_waddr       = rec_reg;
        mem_wdata       = {eff_tag, new_bmp};

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (int'(clr_reg) == NUM_RECORDS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next  = cmd.kind;
                    page_next  = cmd.page;
                    cnt_next   = cmd.count;
                    tag_next   = cmd.type_tag;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                run_page_next = '0;
                ptype_next    = '0;
                done_next     = '0;
                run_next      = '0;
                if (kind_reg == KIND_ALLOC)
                begin
                    ok_next    = 1'b0;
                    off_next   = TOT_W'(top - PAGE_W'(1));
                    state_next = alloc_go ? S_ADDR : S_DONE;
                end
                else
                begin
                    ok_next    = in_region;
                    off_next   = TOT_W'(diff[PAGE_W-1:0]);
                    state_next = in_region ? S_ADDR : S_DONE;
                end
            end
            S_ADDR:
            begin
                rec_next   = off_rec;
                bit_next   = off_bit;
                mem_re     = 1'b1;
                mem_raddr  = off_rec;
                rem_next   = cnt_reg;
                set_next   = (kind_reg != KIND_FREE);
                first_next = 1'b1;
                priority if (kind_reg == KIND_ALLOC)
                begin
                    state_next = S_SCAN;
                end
                else if (kind_reg == KIND_TYPE)
                begin
                    state_next = S_TYPE;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_TOUCH;
                end
            end
            S_SCAN:
            begin
                if (elig && scan_hit)
                begin
                    ok_next       = 1'b1;
                    run_page_next = base_reg + PAGE_W'(start_off);
                    bit_next      = scan_pos;
                    first_next    = 1'b0;
                    mem_re        = 1'b1;
                    state_next    = S_TOUCH;
                end
                else if (rec_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    run_next   = elig ? scan_run : '0;
                    rec_next   = rec_reg - AW'(1);
                    bit_next   = BW'(RECORD_BITS - 1);
                    mem_re     = 1'b1;
                    mem_raddr  = rec_reg - AW'(1);
                end
            end
            S_TOUCH:
            begin
                mem_we     = 1'b1;
                tag_next   = eff_tag;
                first_next = 1'b0;
                used_next  = set_reg ? used_reg + chg_cnt : used_reg - chg_cnt;
                done_next  = done_reg + CNT_W'(tn);
                rem_next   = rem_reg - CNT_W'(tn);
                if (rem_reg == CNT_W'(tn) || int'(rec_inc) >= int'(nrec_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rec_next  = AW'(rec_inc);
                    bit_next  = '0;
                    mem_re    = 1'b1;
                    mem_raddr = AW'(rec_inc);
                end
            end
            S_TYPE:
            begin
                ptype_next = rd_tag;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next     = 1'b1;
                    o_ok_next       = ok_reg;
                    o_run_page_next = run_page_reg;
                    o_done_next     = (kind_reg == KIND_FREE || kind_reg == KIND_CLAIM)
                                      ? done_reg : '0;
                    o_ptype_next    = ptype_reg;
                    o_free_next     = free_w[CNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            used_reg   <= used_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        page_reg       <= page_next;
        cnt_reg        <= cnt_next;
        tag_reg        <= tag_next;
        off_reg        <= off_next;
        rec_reg        <= rec_next;
        bit_reg        <= bit_next;
        run_reg        <= run_next;
        rem_reg        <= rem_next;
        done_reg       <= done_next;
        set_reg        <= set_next;
        first_reg      <= first_next;
        ok_reg         <= ok_next;
        run_page_reg   <= run_page_next;
        ptype_reg      <= ptype_next;
        o_ok_reg       <= o_ok_next;
        o_run_page_reg <= o_run_page_next;
        o_done_reg     <= o_done_next;
        o_ptype_reg    <= o_ptype_next;
        o_free_reg     <= o_free_next;
    end

    // channel outputs
    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ovalid_reg;
    assign rsp.ok         = o_ok_reg;
    assign rsp.run_page   = o_run_page_reg;
    assign rsp.pages_done = o_done_reg;
    assign rsp.page_type  = o_ptype_reg;
    assign rsp.free_pages = o_free_reg;

    // the downward search never writes the record memory
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !mem_we)
        else $error("record written during search");

    // a new response appears only after a finished request
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("response without finished request");

    // a failed request carries no run page
    a_fail_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.run_page == '0))
        else $error("failed request reports a run page");

endmodule
